// ===== design/rsa_me_pkg.sv =====
// shared types, constants and product schedule for the modular exponentiation block
`default_nettype none
package rsa_me_pkg;

  localparam int MAX_WORDS = 64;
  localparam int IDX_W     = $clog2(MAX_WORDS);
  localparam int WORD_W    = 32;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 5;
  localparam int MIN_WORDS = 2;
  localparam int LAST_STEP_E3     = 3;
  localparam int LAST_STEP_E65537 = 17;

  localparam logic [1:0] FUNC_MOD   = 2'd0;
  localparam logic [1:0] FUNC_RSQ   = 2'd1;
  localparam logic [1:0] FUNC_MSG   = 2'd2;
  localparam logic [1:0] FUNC_START = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_NEG_INV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WCOUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMODE   = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] word_value;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_word;
    logic [IDX_W-1:0]  result_index;
    logic              last;
  } out_t;

  typedef enum logic [2:0] {
    SRC_MSG = 3'd0,
    SRC_RSQ = 3'd1,
    SRC_POW = 3'd2,
    SRC_TMP = 3'd3,
    SRC_ONE = 3'd4
  } src_t;

  typedef enum logic {
    DST_POW = 1'b0,
    DST_TMP = 1'b1
  } dst_t;

  typedef struct packed {
    src_t x_src;
    src_t y_src;
    dst_t dst;
  } plan_t;

  function automatic logic [STEP_W-1:0] last_step(input logic mode);
    return mode ? STEP_W'(LAST_STEP_E65537) : STEP_W'(LAST_STEP_E3);
  endfunction

  function automatic plan_t prod_plan(input logic mode, input logic [STEP_W-1:0] step);
    plan_t p;
    p = '{x_src: SRC_MSG, y_src: SRC_RSQ, dst: DST_POW};
    if (step == '0) begin
      p = '{x_src: SRC_MSG, y_src: SRC_RSQ, dst: DST_POW};
    end else if (mode) begin
      if (step == STEP_W'(LAST_STEP_E65537)) begin
        p = '{x_src: SRC_POW, y_src: SRC_MSG, dst: DST_TMP};
      end else if (step[0]) begin
        p = '{x_src: SRC_POW, y_src: SRC_POW, dst: DST_TMP};
      end else begin
        p = '{x_src: SRC_TMP, y_src: SRC_TMP, dst: DST_POW};
      end
    end else begin
      case (step)
        STEP_W'(1): p = '{x_src: SRC_POW, y_src: SRC_POW, dst: DST_TMP};
        STEP_W'(2): p = '{x_src: SRC_TMP, y_src: SRC_POW, dst: DST_TMP};
        default:    p = '{x_src: SRC_TMP, y_src: SRC_ONE, dst: DST_TMP};
      endcase
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== design/rsa_me_ram.sv =====
// generic single write, single registered read memory
`default_nettype none
module rsa_me_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/rsa_public_modexp_montgomery.sv =====
// rsa public exponent modexp top level: loads, montgomery sequencer, result words
// load words are taken only while idle; start is followed by the exponentiation
// each montgomery product runs on the shared 32x32 multiplier pair;
// an exponentiation takes 4 products for e = 3, 18 for e = 65537
// result words then leave one at a time, each held until accepted, top word first
// synchronous reset clears control and neg_inv, sets word count 64 and e = 65537; stores hold nothing until loaded
`default_nettype none
module rsa_public_modexp_montgomery
  import rsa_me_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_t                      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data
);

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_PINIT = 14'b00000000000010,
    ST_Y0    = 14'b00000000000100,
    ST_MUB   = 14'b00000000001000,
    ST_RADDR = 14'b00000000010000,
    ST_RX    = 14'b00000000100000,
    ST_RQ    = 14'b00000001000000,
    ST_RUN   = 14'b00000010000000,
    ST_TAIL  = 14'b00000100000000,
    ST_DIFF  = 14'b00001000000000,
    ST_SEL   = 14'b00010000000000,
    ST_OADDR = 14'b00100000000000,
    ST_OLOAD = 14'b01000000000000,
    ST_OWAIT = 14'b10000000000000
  } state_t;

  state_t state;

  logic [WORD_W-1:0] neg_inv;
  logic [CNT_W-1:0]  wcount;
  logic              emode;

  logic [IDX_W-1:0]  wm1, icnt, jcnt, pos, idx1, idx2, opaddr, opaddr_q;
  logic [STEP_W-1:0] step;
  logic              issued_all, v1, v2, first_row, borrow, carry;
  logic [WORD_W-1:0] mub0, x_reg, q, tp, tr, pa_s, ra_s;
  logic [63:0]       prod_a, prod_b;

  logic [WORD_W-1:0] mod_rdata, rsq_rdata, msg_rdata, pow_rdata, tmp_rdata;
  logic [WORD_W-1:0] pa_rdata, ra_rdata;

  logic [WORD_W-1:0] mu, opdata, pa_eff, ra_eff, c0;
  logic [WORD_W-1:0] mula, mulb, mulc, muld;
  logic [63:0]       sum_p, sum_r;
  logic [32:0]       diff33, sum33;
  logic [CNT_W-1:0]  wdec;
  logic [IDX_W-1:0]  wm1_start;
  logic              issue, load_we, start, sel_we;
  logic              acc_we;
  logic [IDX_W-1:0]  acc_waddr;
  logic [WORD_W-1:0] pa_wdata, ra_wdata, sel_data;
  src_t              rd_src;
  plan_t             plan;

  assign in_ready  = (state == ST_IDLE);
  assign load_we   = in_valid && in_ready && (in_data.func != FUNC_START);
  assign start     = in_valid && in_ready && (in_data.func == FUNC_START);
  assign mu        = WORD_W'(0) - neg_inv;
  assign plan      = prod_plan(emode, step);
  assign issue     = ((state == ST_RUN) || (state == ST_DIFF) || (state == ST_SEL))
                     && !issued_all;
  assign wdec      = wcount - CNT_W'(1);
  assign wm1_start = (wcount < CNT_W'(MIN_WORDS)) ? IDX_W'(MIN_WORDS - 1) :
                     (wcount > CNT_W'(MAX_WORDS)) ? IDX_W'(MAX_WORDS - 1) :
                     wdec[IDX_W-1:0];

  always_comb begin
    case (state)
      ST_PINIT: opaddr = '0;
      ST_RADDR: opaddr = jcnt;
      ST_OADDR: opaddr = pos;
      default:  opaddr = icnt;
    endcase
  end

  assign rd_src = (state == ST_RX) ? plan.x_src : plan.y_src;

  always_comb begin
    case (rd_src)
      SRC_MSG: opdata = msg_rdata;
      SRC_RSQ: opdata = rsq_rdata;
      SRC_POW: opdata = pow_rdata;
      SRC_TMP: opdata = tmp_rdata;
      SRC_ONE: opdata = WORD_W'(opaddr_q == '0);
      default: opdata = '0;
    endcase
  end

  assign pa_eff = first_row ? '0 : pa_rdata;
  assign ra_eff = first_row ? '0 : ra_rdata;
  assign c0     = pa_eff - ra_eff;

  // shared multiplier pair operand selection
  always_comb begin
    if (state == ST_RX) begin
      mula = mu;
      mulb = c0;
      mulc = mub0;
      muld = opdata;
    end else if (state == ST_Y0) begin
      mula = mu;
      mulb = opdata;
      mulc = '0;
      muld = '0;
    end else begin
      mula = x_reg;
      mulb = opdata;
      mulc = q;
      muld = mod_rdata;
    end
  end

  assign sum_p  = 64'(tp) + 64'(pa_s) + prod_a;
  assign sum_r  = 64'(tr) + 64'(ra_s) + prod_b;
  assign diff33 = {1'b0, pa_rdata} - {1'b0, ra_rdata} - 33'(borrow);
  assign sum33  = {1'b0, diff33[WORD_W-1:0]} + {1'b0, mod_rdata} + 33'(carry);

  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = idx1;
    pa_wdata  = sum33[WORD_W-1:0];
    ra_wdata  = diff33[WORD_W-1:0];
    case (state)
      ST_RUN: begin
        acc_we    = v2 && (idx2 != '0);
        acc_waddr = idx2 - IDX_W'(1);
        pa_wdata  = sum_p[WORD_W-1:0];
        ra_wdata  = sum_r[WORD_W-1:0];
      end
      ST_TAIL: begin
        acc_we    = 1'b1;
        acc_waddr = wm1;
        pa_wdata  = tp;
        ra_wdata  = tr;
      end
      ST_DIFF: begin
        acc_we = v1;
      end
      default: begin
        acc_we = 1'b0;
      end
    endcase
  end

  assign sel_we   = (state == ST_SEL) && v1;
  assign sel_data = borrow ? pa_rdata : ra_rdata;

  rsa_me_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WORDS)) u_mod_ram (
    .clk, .we(load_we && (in_data.func == FUNC_MOD)), .waddr(in_data.word_index),
    .wdata(in_data.word_value), .raddr(icnt), .rdata(mod_rdata)
  );

  rsa_me_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WORDS)) u_rsq_ram (
    .clk, .we(load_we && (in_data.func == FUNC_RSQ)), .waddr(in_data.word_index),
    .wdata(in_data.word_value), .raddr(opaddr), .rdata(rsq_rdata)
  );

  rsa_me_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WORDS)) u_msg_ram (
    .clk, .we(load_we && (in_data.func == FUNC_MSG)), .waddr(in_data.word_index),
    .wdata(in_data.word_value), .raddr(opaddr), .rdata(msg_rdata)
  );

  rsa_me_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WORDS)) u_pow_ram (
    .clk, .we(sel_we && (plan.dst == DST_POW)), .waddr(idx1),
    .wdata(sel_data), .raddr(opaddr), .rdata(pow_rdata)
  );

  rsa_me_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WORDS)) u_tmp_ram (
    .clk, .we(sel_we && (plan.dst == DST_TMP)), .waddr(idx1),
    .wdata(sel_data), .raddr(opaddr), .rdata(tmp_rdata)
  );

  rsa_me_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WORDS)) u_pa_ram (
    .clk, .we(acc_we), .waddr(acc_waddr), .wdata(pa_wdata), .raddr(icnt), .rdata(pa_rdata)
  );

  rsa_me_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WORDS)) u_ra_ram (
    .clk, .we(acc_we), .waddr(acc_waddr), .wdata(ra_wdata), .raddr(icnt), .rdata(ra_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      issued_all <= 1'b0;
      icnt       <= '0;
      neg_inv    <= '0;
      wcount     <= CNT_W'(MAX_WORDS);
      emode      <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NEG_INV: neg_inv <= cfg_data;
          CFG_WCOUNT:  wcount  <= cfg_data[CNT_W-1:0];
          CFG_EMODE:   emode   <= cfg_data[0];
          default:     ;
        endcase
      end

      opaddr_q <= opaddr;
      prod_a   <= mula * mulb;
      prod_b   <= mulc * muld;
      v1       <= issue;
      idx1     <= icnt;
      v2       <= v1 && (state == ST_RUN);
      idx2     <= idx1;
      pa_s     <= pa_eff;
      ra_s     <= ra_eff;
      if (issue) begin
        icnt <= icnt + IDX_W'(1);
        if (icnt == wm1) begin
          issued_all <= 1'b1;
        end
      end

      case (state)
        ST_IDLE: begin
          if (start) begin
            wm1   <= wm1_start;
            step  <= '0;
            state <= ST_PINIT;
          end
        end
        ST_PINIT: begin
          first_row <= 1'b1;
          jcnt      <= '0;
          state     <= ST_Y0;
        end
        ST_Y0: begin
          state <= ST_MUB;
        end
        ST_MUB: begin
          mub0  <= prod_a[WORD_W-1:0];
          icnt  <= '0;
          state <= ST_RADDR;
        end
        ST_RADDR: begin
          state <= ST_RX;
        end
        ST_RX: begin
          x_reg <= opdata;
          state <= ST_RQ;
        end
        ST_RQ: begin
          q          <= prod_a[WORD_W-1:0] + prod_b[WORD_W-1:0];
          tp         <= '0;
          tr         <= '0;
          icnt       <= '0;
          issued_all <= 1'b0;
          state      <= ST_RUN;
        end
        ST_RUN: begin
          if (v2) begin
            tp <= sum_p[63:WORD_W];
            tr <= sum_r[63:WORD_W];
            if (idx2 == wm1) begin
              state <= ST_TAIL;
            end
          end
        end
        ST_TAIL: begin
          first_row  <= 1'b0;
          icnt       <= '0;
          issued_all <= 1'b0;
          if (jcnt == wm1) begin
            borrow <= 1'b0;
            carry  <= 1'b0;
            state  <= ST_DIFF;
          end else begin
            jcnt  <= jcnt + IDX_W'(1);
            state <= ST_RADDR;
          end
        end
        ST_DIFF: begin
          if (v1) begin
            borrow <= diff33[WORD_W];
            carry  <= sum33[WORD_W];
            if (idx1 == wm1) begin
              icnt       <= '0;
              issued_all <= 1'b0;
              state      <= ST_SEL;
            end
          end
        end
        ST_SEL: begin
          if (v1 && (idx1 == wm1)) begin
            if (step == last_step(emode)) begin
              pos   <= wm1;
              state <= ST_OADDR;
            end else begin
              step  <= step + STEP_W'(1);
              state <= ST_PINIT;
            end
          end
        end
        ST_OADDR: begin
          state <= ST_OLOAD;
        end
        ST_OLOAD: begin
          out_data  <= '{result_word: tmp_rdata, result_index: pos, last: (pos == '0)};
          out_valid <= 1'b1;
          state     <= ST_OWAIT;
        end
        ST_OWAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (pos == '0) begin
              state <= ST_IDLE;
            end else begin
              pos   <= pos - IDX_W'(1);
              state <= ST_OADDR;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_onehot_state: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");

  a_out_only_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_OWAIT))
    else $error("result word shown outside wait state");

  a_no_acc_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !acc_we)
    else $error("accumulator write while idle");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last) |=> (state == ST_IDLE))
    else $error("final word did not return to idle");

  a_stage2_run: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(state == ST_RUN))
    else $error("product stage active outside row pass");

endmodule
`default_nettype wire

// ===== tb/rsa_me_checker.sv =====
// predictor and result comparison for the modular exponentiation block
`timescale 1ns / 1ps
`default_nettype none
module rsa_me_checker
  import rsa_me_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire in_t                  in_data,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire out_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  output int                        errors,
  output int                        words_due
);

  typedef logic [31:0] vec_t [MAX_WORDS];

  logic [31:0] neg_inv;
  logic [6:0]  wcount;
  logic        emode;
  vec_t        mod_s, rsq_s, msg_s, pow_s, tmp_s;
  out_t        due_q[$];

  assign words_due = due_q.size();

  function automatic int span();
    if (wcount < 7'(MIN_WORDS)) return MIN_WORDS;
    if (wcount > 7'(MAX_WORDS)) return MAX_WORDS;
    return int'(wcount);
  endfunction

  // x * y / R modulo N, selected difference not reduced further
  function automatic vec_t mont_mul(vec_t x, vec_t y, int w);
    logic [63:0] pa [MAX_WORDS];
    logic [63:0] ra [MAX_WORDS];
    logic [63:0] p, r, tp, tr, s;
    logic [31:0] mu, mub0, c0, q, d, e, diff, borrow, carry;
    vec_t res;
    res = y;
    mu = 32'd0 - neg_inv;
    mub0 = 32'(64'(mu) * 64'(y[0]));
    borrow = 0;
    carry = 0;
    for (int i = 0; i < w; i++) begin
      pa[i] = 0;
      ra[i] = 0;
    end
    for (int j = 0; j < w; j++) begin
      c0 = 32'(pa[0] - ra[0]);
      q = 32'(64'(mu) * 64'(c0) + 64'(mub0) * 64'(x[j]));
      p = pa[0] + 64'(x[j]) * 64'(y[0]);
      r = ra[0] + 64'(q) * 64'(mod_s[0]);
      tp = p >> 32;
      tr = r >> 32;
      for (int i = 1; i < w; i++) begin
        p = tp + pa[i] + 64'(x[j]) * 64'(y[i]);
        r = tr + ra[i] + 64'(q) * 64'(mod_s[i]);
        tp = p >> 32;
        tr = r >> 32;
        pa[i-1] = p & 64'hffffffff;
        ra[i-1] = r & 64'hffffffff;
      end
      pa[w-1] = tp;
      ra[w-1] = tr;
    end
    for (int i = 0; i < w; i++) begin
      d = pa[i][31:0];
      e = ra[i][31:0];
      diff = d - e - borrow;
      borrow = ((~d & e) | ((~d | e) & diff)) >> 31;
      ra[i] = 64'(diff);
    end
    for (int i = 0; i < w; i++) begin
      s = ra[i] + 64'(mod_s[i]) + 64'(carry);
      carry = 32'(s >> 32);
      pa[i] = s & 64'hffffffff;
    end
    for (int i = 0; i < w; i++) res[i] = borrow[0] ? pa[i][31:0] : ra[i][31:0];
    return res;
  endfunction

  task automatic predict_power();
    int w;
    out_t o;
    w = span();
    pow_s = mont_mul(msg_s, rsq_s, w);
    if (!emode) begin
      tmp_s = mont_mul(pow_s, pow_s, w);
      tmp_s = mont_mul(tmp_s, pow_s, w);
      for (int i = 0; i < w; i++) pow_s[i] = (i == 0) ? 32'd1 : 32'd0;
      tmp_s = mont_mul(tmp_s, pow_s, w);
    end else begin
      for (int i = 0; i < 16; i += 2) begin
        tmp_s = mont_mul(pow_s, pow_s, w);
        pow_s = mont_mul(tmp_s, tmp_s, w);
      end
      tmp_s = mont_mul(pow_s, msg_s, w);
    end
    for (int k = 0; k < w; k++) begin
      o.result_word  = tmp_s[w-1-k];
      o.result_index = IDX_W'(w - 1 - k);
      o.last         = (w - 1 - k) == 0;
      due_q.push_back(o);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      neg_inv <= '0;
      wcount  <= 7'd64;
      emode   <= 1'b1;
      errors  <= 0;
      due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NEG_INV: neg_inv <= cfg_data;
          CFG_WCOUNT:  wcount  <= cfg_data[6:0];
          CFG_EMODE:   emode   <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_data.func)
          FUNC_MOD:   mod_s[in_data.word_index] = in_data.word_value;
          FUNC_RSQ:   rsq_s[in_data.word_index] = in_data.word_value;
          FUNC_MSG:   msg_s[in_data.word_index] = in_data.word_value;
          FUNC_START: predict_power();
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
          errors <= errors + 1;
        end else begin
          if (out_data !== due_q[0]) begin
            $display("%0t: word mismatch, expected %h/%0d/%0d, actual %h/%0d/%0d", $time,
                     due_q[0].result_word, due_q[0].result_index, due_q[0].last,
                     out_data.result_word, out_data.result_index, out_data.last);
            errors <= errors + 1;
          end
          void'(due_q.pop_front());
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// stimulus and verdict for the modular exponentiation block
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import rsa_me_pkg::*;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 in_valid = 0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 0;
  out_t                 out_data;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_NEG_INV;
  logic [WORD_W-1:0]    cfg_data = '0;
  int                   errors, words_due;

  logic        quiet = 0;
  int          cur_w = 64;
  int          items = 0, results = 0;
  logic [63:0] loaded [3];
  logic [31:0] mod_low = 32'd1;

  always #5 clk = ~clk;

  rsa_public_modexp_montgomery uut (.*);

  rsa_me_checker chk (.*);

  task automatic send(logic [1:0] f, int idx, logic [31:0] v);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{func: f, word_index: IDX_W'(idx), word_value: v};
    do @(posedge clk); while (!in_ready);
    if (f != FUNC_START) begin
      loaded[f][idx] = 1'b1;
      if (f == FUNC_MOD && idx == 0) mod_low = v;
    end else begin
      results += cur_w;
    end
    items++;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    in_valid  <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WCOUNT) begin
      cur_w = int'(v[6:0]);
      if (cur_w < MIN_WORDS) cur_w = MIN_WORDS;
      if (cur_w > MAX_WORDS) cur_w = MAX_WORDS;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] odd_word();
    return $urandom() | 32'd1;
  endfunction

  // -1/n mod 2^32 for odd n
  function automatic logic [31:0] neg_inverse_of(logic [31:0] n);
    logic [31:0] inv;
    inv = n;
    for (int i = 0; i < 5; i++) inv = inv * (32'd2 - n * inv);
    return 32'd0 - inv;
  endfunction

  task automatic fill_missing();
    for (int f = 0; f < 3; f++)
      for (int i = 0; i < cur_w; i++)
        if (!loaded[f][i])
          send(2'(f), i, (f == 0 && i == 0) ? odd_word() : $urandom());
  endtask

  task automatic power_run();
    fill_missing();
    send(FUNC_START, $urandom_range(0, 63), $urandom());
    settle();
  endtask

  initial begin
    int n;
    loaded[0] = '0;
    loaded[1] = '0;
    loaded[2] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: word count saturates low, extreme words
    cfg_write(CFG_WCOUNT, 32'd0);
    cfg_write(CFG_EMODE, 32'd0);
    send(FUNC_MOD, 0, 32'hffffffff);
    send(FUNC_MOD, 1, 32'hffffffff);
    send(FUNC_RSQ, 0, 32'h0);
    send(FUNC_RSQ, 1, 32'h1);
    send(FUNC_MSG, 0, 32'hffffffff);
    send(FUNC_MSG, 1, 32'h0);
    cfg_write(CFG_NEG_INV, neg_inverse_of(32'hffffffff));
    power_run();
    cfg_write(CFG_EMODE, 32'd1);
    send(FUNC_MSG, 63, 32'hffffffff);
    send(FUNC_RSQ, 40, 32'h0);
    power_run();
    cfg_write(CFG_NEG_INV, 32'hffffffff);
    cfg_write(CFG_WCOUNT, 32'd3);
    send(FUNC_MOD, 2, 32'h80000000);
    send(FUNC_RSQ, 2, 32'hffffffff);
    send(FUNC_MSG, 2, 32'hffffffff);
    power_run();
    cfg_write(CFG_WCOUNT, 32'd1);
    power_run();

    // random phases, mostly small word counts
    while (items < 100 || results < 48) begin
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       cfg_write(CFG_WCOUNT, ($urandom_range(0, 4) == 0) ? 32'd127 : 32'd64);
        1:       cfg_write(CFG_WCOUNT, $urandom());
        2:       cfg_write(CFG_WCOUNT, $urandom_range(0, 1));
        default: cfg_write(CFG_WCOUNT, $urandom_range(2, 8));
      endcase
      cfg_write(CFG_EMODE, $urandom_range(0, 1));
      n = $urandom_range(0, 12);
      for (int k = 0; k < n; k++)
        send(2'($urandom_range(0, 2)), $urandom_range(0, 63), $urandom());
      if ($urandom_range(0, 4) != 0) send(FUNC_MOD, 0, odd_word());
      fill_missing();
      if ($urandom_range(0, 5) == 0) cfg_write(CFG_NEG_INV, $urandom());
      else cfg_write(CFG_NEG_INV, neg_inverse_of(mod_low));
      power_run();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int gap;
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #400ms;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
design/rsa_me_pkg.sv
design/rsa_me_ram.sv
design/rsa_public_modexp_montgomery.sv
tb/rsa_me_checker.sv
tb/tb_top.sv
